// ===== hw/rtl/aud_stat_pkg.sv =====
// ----------------------------------------------------------------------------
// aud_stat_pkg: shared constants for the audio sample statistics block
// Field widths, counter width, histogram bin codes and stream layout.
// ----------------------------------------------------------------------------
package aud_stat_pkg;

  // Field widths
  localparam int SAMPLE_W    = 32;
  localparam int ACC_W       = 64;
  localparam int COUNT_OUT_W = 40;

  // Counter width (count and histogram pairs), valid from 16 to 64
  localparam int COUNT_BITS = 40;
  localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = '1;

  // Histogram bin index is (top two bits) xor BIN_OFFSET
  localparam int TOP_SHIFT  = 30;
  localparam int BIN_OFFSET = 2;

  localparam logic [1:0] BIN_NEG_OUTER = 2'd0;  // top bits 10
  localparam logic [1:0] BIN_NEG_INNER = 2'd1;  // top bits 11
  localparam logic [1:0] BIN_POS_INNER = 2'd2;  // top bits 00
  localparam logic [1:0] BIN_POS_OUTER = 2'd3;  // top bits 01

  // Signed accumulator limits
  localparam logic signed [ACC_W-1:0] SUM_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SUM_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Result stream width: 9 wide fields plus the count fields
  localparam int M_DATA_W = 4 * SAMPLE_W + 5 * ACC_W + 3 * COUNT_OUT_W;

endpackage

// ===== hw/rtl/audio_sample_statistics.sv =====
// ----------------------------------------------------------------------------
// audio_sample_statistics: running statistics over a sample stream
// Passes each sample through and reports count, min, max, sums, delta
// statistics and histogram pair counts after each sample.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one request per sample, s_tdata = sample (signed),
//   s_tuser = restart (clears all statistics, sample becomes the first).
//   Master channel m_*: one result per sample carrying the sample and the
//   statistics that include it.
// Pipeline: an accepted sample passes the input register, delta stage,
//   multiply stage and accumulate/result register before m_tvalid.
// Throughput: 1 sample per cycle unless m_tready stalls; the accumulate
//   stage and both 32x32 squaring multipliers take a new item every cycle.
// Reset: all pipeline stages empty; the first sample after reset starts
//   fresh statistics just as a restart does.
// Stall: each stage holds while the one after it is full and blocked; an
//   empty stage still takes data, so input keeps flowing until all four
//   stages are full. Statistics only advance when an item enters the
//   result register.
// ----------------------------------------------------------------------------
module audio_sample_statistics (
  input  logic                                 clk,
  input  logic                                 rst,
  // slave side
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [aud_stat_pkg::SAMPLE_W-1:0]    s_tdata,  // [31:0] sample
  input  logic                                 s_tuser,  // [0] restart
  // master side
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // m_tdata from bit 0 up: sample_out 32, sample_count 40, minimum 32,
  // maximum 32, running_sum 64, square_sum 64, magnitude_sum 64,
  // delta_peak 32, delta_sum 64, delta_square_sum 64, outer_bin_count 40,
  // nonnegative_bin_count 40
  output logic [aud_stat_pkg::M_DATA_W-1:0]    m_tdata
);

  localparam int SW = aud_stat_pkg::SAMPLE_W;
  localparam int AW = aud_stat_pkg::ACC_W;
  localparam int CB = aud_stat_pkg::COUNT_BITS;
  localparam int CW = aud_stat_pkg::COUNT_OUT_W;

  // Stage valids and ready chain
  logic v0, v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  assign rdy3     = !v3 || m_tready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = !v0 || rdy1;
  assign m_tvalid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (s_tready) v0 <= s_tvalid;
      if (rdy1)     v1 <= v0;
      if (rdy2)     v2 <= v1;
      if (rdy3)     v3 <= v2;
    end
  end

  // Stage 0: input register
  logic signed [SW-1:0] r0_sample;
  logic                 r0_restart;

  always_ff @(posedge clk) begin
    if (s_tready) begin
      r0_sample  <= s_tdata;
      r0_restart <= s_tuser;
    end
  end

  // Stage 1: first flag, magnitude, delta and bin flags
  logic                 seen;
  logic signed [SW-1:0] prev_sample;
  logic                 first1;
  logic signed [SW:0]   diff1;
  logic [SW:0]          diff_abs1;
  logic [SW-1:0]        mag1;
  logic [SW-1:0]        delta1;
  logic [1:0]           bin1;
  logic                 t1;

  assign t1     = v0 && rdy1;
  assign first1 = r0_restart || !seen;

  always_comb begin
    diff1     = first1 ? '0 : (SW+1)'(r0_sample) - (SW+1)'(prev_sample);
    diff_abs1 = diff1[SW] ? (SW+1)'(-diff1) : (SW+1)'(diff1);
    delta1    = diff_abs1[SW-1:0];
    mag1      = r0_sample[SW-1] ? SW'(-r0_sample) : SW'(r0_sample);
    bin1      = 2'(SW'(r0_sample) >> aud_stat_pkg::TOP_SHIFT)
                ^ 2'(aud_stat_pkg::BIN_OFFSET);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
    end else if (t1) begin
      seen <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (t1) prev_sample <= r0_sample;
  end

  logic signed [SW-1:0] r1_sample;
  logic                 r1_first;
  logic [SW-1:0]        r1_mag;
  logic [SW-1:0]        r1_delta;
  logic                 r1_outer;
  logic                 r1_nonneg;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      r1_sample <= r0_sample;
      r1_first  <= first1;
      r1_mag    <= mag1;
      r1_delta  <= delta1;
      r1_outer  <= (bin1 == aud_stat_pkg::BIN_NEG_OUTER)
                || (bin1 == aud_stat_pkg::BIN_POS_OUTER);
      r1_nonneg <= (bin1 == aud_stat_pkg::BIN_POS_INNER)
                || (bin1 == aud_stat_pkg::BIN_POS_OUTER);
    end
  end

  // Stage 2: squares, upper half kept
  logic [2*SW-1:0] mag_prod;
  logic [2*SW-1:0] delta_prod;

  assign mag_prod   = (2*SW)'(r1_mag) * (2*SW)'(r1_mag);
  assign delta_prod = (2*SW)'(r1_delta) * (2*SW)'(r1_delta);

  logic signed [SW-1:0] r2_sample;
  logic                 r2_first;
  logic [SW-1:0]        r2_mag;
  logic [SW-1:0]        r2_delta;
  logic [SW-1:0]        r2_mag_sq;
  logic [SW-1:0]        r2_delta_sq;
  logic                 r2_outer;
  logic                 r2_nonneg;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      r2_sample   <= r1_sample;
      r2_first    <= r1_first;
      r2_mag      <= r1_mag;
      r2_delta    <= r1_delta;
      r2_mag_sq   <= mag_prod[2*SW-1:SW];
      r2_delta_sq <= delta_prod[2*SW-1:SW];
      r2_outer    <= r1_outer;
      r2_nonneg   <= r1_nonneg;
    end
  end

  // Stage 3: statistics registers, which are also the result register
  logic signed [SW-1:0] sample_out;
  logic [CB-1:0]        count;
  logic signed [SW-1:0] minimum;
  logic signed [SW-1:0] maximum;
  logic signed [AW-1:0] running_sum;
  logic [AW-1:0]        square_sum;
  logic [AW-1:0]        magnitude_sum;
  logic [SW-1:0]        delta_peak;
  logic [AW-1:0]        delta_sum;
  logic [AW-1:0]        delta_square_sum;
  logic [CB-1:0]        outer_count;
  logic [CB-1:0]        nonneg_count;

  logic [CB-1:0]        count_next;
  logic signed [SW-1:0] minimum_next;
  logic signed [SW-1:0] maximum_next;
  logic signed [AW-1:0] running_sum_next;
  logic [AW-1:0]        square_sum_next;
  logic [AW-1:0]        magnitude_sum_next;
  logic [SW-1:0]        delta_peak_next;
  logic [AW-1:0]        delta_sum_next;
  logic [AW-1:0]        delta_square_sum_next;
  logic [CB-1:0]        outer_count_next;
  logic [CB-1:0]        nonneg_count_next;

  logic                 t3;
  logic [CB-1:0]        count_base, outer_base, nonneg_base;
  logic signed [SW-1:0] min_base, max_base;
  logic signed [AW-1:0] sum_base, sum_add, sum_raw;
  logic [AW:0]          sq_raw, mag_raw, dsum_raw, dsq_raw;
  logic [SW-1:0]        peak_base;

  assign t3 = v2 && rdy3;

  always_comb begin
    // a first sample starts from cleared statistics
    count_base  = r2_first ? '0 : count;
    outer_base  = r2_first ? '0 : outer_count;
    nonneg_base = r2_first ? '0 : nonneg_count;
    min_base    = r2_first ? r2_sample : minimum;
    max_base    = r2_first ? r2_sample : maximum;
    sum_base    = r2_first ? '0 : running_sum;
    peak_base   = r2_first ? '0 : delta_peak;

    // saturating counters
    count_next        = (count_base == aud_stat_pkg::COUNT_LIMIT) ? count_base
                        : count_base + CB'(1);
    outer_count_next  = (!r2_outer || outer_base == aud_stat_pkg::COUNT_LIMIT)
                        ? outer_base : outer_base + CB'(1);
    nonneg_count_next = (!r2_nonneg || nonneg_base == aud_stat_pkg::COUNT_LIMIT)
                        ? nonneg_base : nonneg_base + CB'(1);

    // new minimum first, otherwise new maximum
    minimum_next = min_base;
    maximum_next = max_base;
    if (min_base > r2_sample) begin
      minimum_next = r2_sample;
    end else if (max_base < r2_sample) begin
      maximum_next = r2_sample;
    end

    // saturating signed sum
    sum_add = AW'(r2_sample);
    sum_raw = sum_base + sum_add;
    if (sum_base[AW-1] == sum_add[AW-1] && sum_raw[AW-1] != sum_base[AW-1]) begin
      running_sum_next = sum_add[AW-1] ? aud_stat_pkg::SUM_MIN
                                       : aud_stat_pkg::SUM_MAX;
    end else begin
      running_sum_next = sum_raw;
    end

    // saturating unsigned sums
    sq_raw   = (r2_first ? '0 : (AW+1)'(square_sum)) + (AW+1)'(r2_mag_sq);
    mag_raw  = (r2_first ? '0 : (AW+1)'(magnitude_sum)) + (AW+1)'(r2_mag);
    dsum_raw = (r2_first ? '0 : (AW+1)'(delta_sum)) + (AW+1)'(r2_delta);
    dsq_raw  = (r2_first ? '0 : (AW+1)'(delta_square_sum)) + (AW+1)'(r2_delta_sq);

    square_sum_next       = sq_raw[AW]   ? '1 : sq_raw[AW-1:0];
    magnitude_sum_next    = mag_raw[AW]  ? '1 : mag_raw[AW-1:0];
    delta_sum_next        = dsum_raw[AW] ? '1 : dsum_raw[AW-1:0];
    delta_square_sum_next = dsq_raw[AW]  ? '1 : dsq_raw[AW-1:0];

    // delta peak
    delta_peak_next = (r2_delta > peak_base) ? r2_delta : peak_base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count            <= '0;
      minimum          <= '0;
      maximum          <= '0;
      running_sum      <= '0;
      square_sum       <= '0;
      magnitude_sum    <= '0;
      delta_peak       <= '0;
      delta_sum        <= '0;
      delta_square_sum <= '0;
      outer_count      <= '0;
      nonneg_count     <= '0;
    end else if (t3) begin
      count            <= count_next;
      minimum          <= minimum_next;
      maximum          <= maximum_next;
      running_sum      <= running_sum_next;
      square_sum       <= square_sum_next;
      magnitude_sum    <= magnitude_sum_next;
      delta_peak       <= delta_peak_next;
      delta_sum        <= delta_sum_next;
      delta_square_sum <= delta_square_sum_next;
      outer_count      <= outer_count_next;
      nonneg_count     <= nonneg_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (t3) sample_out <= r2_sample;
  end

  // Count outputs carry the low bits of the counters
  logic [63:0] count_ext, outer_ext, nonneg_ext;

  assign count_ext  = 64'(count);
  assign outer_ext  = 64'(outer_count);
  assign nonneg_ext = 64'(nonneg_count);

  assign m_tdata = {nonneg_ext[CW-1:0], outer_ext[CW-1:0], delta_square_sum,
                    delta_sum, delta_peak, magnitude_sum, square_sum,
                    running_sum, maximum, minimum, count_ext[CW-1:0],
                    sample_out};

  // Checks
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (count != '0))
    else $error("result shown with zero sample count");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (minimum <= maximum))
    else $error("minimum above maximum");

  a_peak_in_sum: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (delta_sum >= AW'(delta_peak)))
    else $error("delta peak exceeds delta sum");

  a_bins_le_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (nonneg_count <= count && outer_count <= count))
    else $error("histogram pair count exceeds sample count");

  a_stats_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> ($stable(count) && $stable(running_sum)))
    else $error("statistics changed while result stalled");

endmodule
